FILE: hdl/lzw_byte_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// lzw byte stream decoder assertion macros
// shared property forms for the decoder checks
// ----------------------------------------------------------------------------
`ifndef LZW_BYTE_STREAM_DECODER_MACROS_SVH
`define LZW_BYTE_STREAM_DECODER_MACROS_SVH

// condition holds at every edge out of reset
`define LZWD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define LZWD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// types and constants shared by the lzw decoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package lzwd_pkg;

	localparam int DICT_ENTRIES = 4096;
	localparam int MAX_STRING   = 64;
	localparam int LIT_CODES    = 256;
	localparam int CODE_W       = $clog2(DICT_ENTRIES);
	localparam int NF_W         = CODE_W + 1;
	localparam int LEN_W        = $clog2(MAX_STRING + 1);
	localparam int SP_W         = $clog2(MAX_STRING);
	localparam int STREAM_W     = 16;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_FIRST = 2'd1,
		ST_TRUNC     = 2'd2,
		ST_TOO_LONG  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDPREV,
		S_RDCODE,
		S_DECIDE,
		S_WALK,
		S_EMIT_RD,
		S_EMIT_OUT,
		S_STATUS
	} state_t;

	typedef struct packed {
		logic [CODE_W-1:0] prefix;
		logic [7:0]        suffix;
		logic [7:0]        first;
		logic [LEN_W-1:0]  len;
	} entry_t;

endpackage

`default_nettype wire

FILE: hdl/lzwd_if.sv
// ----------------------------------------------------------------------------
// lzwd channel interfaces
// valid/ready channels for packed input words and decoded output words
// ----------------------------------------------------------------------------
`default_nettype none

interface lzwd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface lzwd_out_if;
	logic              valid;
	logic              ready;
	logic [7:0]        data_byte;
	logic              has_data;
	logic              run_last;
	lzwd_pkg::status_t status;
	modport source (output valid, data_byte, has_data, run_last, status, input ready);
	modport sink (input valid, data_byte, has_data, run_last, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/lzwd_dict.sv
// ----------------------------------------------------------------------------
// lzwd_dict
// dictionary memory, one write and one registered read, literal codes implicit
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_dict (
	input  wire logic                      clk,
	input  wire logic [lzwd_pkg::CODE_W-1:0] rd_addr,
	input  wire logic                      we,
	input  wire logic [lzwd_pkg::CODE_W-1:0] wr_addr,
	input  wire lzwd_pkg::entry_t          wr_ent,
	output lzwd_pkg::entry_t               rd_ent
);

	lzwd_pkg::entry_t mem [lzwd_pkg::DICT_ENTRIES];
	lzwd_pkg::entry_t raw_q;
	logic             lit_q;
	logic [7:0]       lit_byte_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_ent;
		end
		raw_q      <= mem[rd_addr];
		lit_q      <= rd_addr < lzwd_pkg::CODE_W'(lzwd_pkg::LIT_CODES);
		lit_byte_q <= rd_addr[7:0];
	end

	// literal codes are never stored
	always_comb begin
		if (lit_q) begin
			rd_ent.prefix = '0;
			rd_ent.suffix = lit_byte_q;
			rd_ent.first  = lit_byte_q;
			rd_ent.len    = lzwd_pkg::LEN_W'(1);
		end else begin
			rd_ent = raw_q;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/lzwd_stack.sv
// ----------------------------------------------------------------------------
// lzwd_stack
// string reversal buffer, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_stack (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [lzwd_pkg::SP_W-1:0] waddr,
	input  wire logic [7:0]              wdata,
	input  wire logic [lzwd_pkg::SP_W-1:0] raddr,
	output logic [7:0]                   rdata
);

	logic [7:0] mem [lzwd_pkg::MAX_STRING];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/lzw_byte_stream_decoder.sv
// ----------------------------------------------------------------------------
// lzw_byte_stream_decoder
// 12-bit lzw decompressor fed one packed byte per word
// ----------------------------------------------------------------------------
// sequence: a word that completes a code reads the previous and current entries,
//   decides, walks the chain one string byte per step, then reads and emits each
//   decoded output word; the single dictionary read port sets the pace, an output
//   stall holds the emit, and no new word is taken until that code is done
// reset: arst_n clears the sequencer, phase, error and dictionary fill count;
//   the dictionary memory is not cleared, entries are always written before use
`default_nettype none

`include "lzw_byte_stream_decoder_macros.svh"

module lzw_byte_stream_decoder (
	input wire logic clk,
	input wire logic arst_n,
	lzwd_in_if.sink    src,
	lzwd_out_if.source dst
);

	localparam int CW = lzwd_pkg::CODE_W;
	localparam int NW = lzwd_pkg::NF_W;
	localparam int LW = lzwd_pkg::LEN_W;
	localparam int PW = lzwd_pkg::SP_W;
	localparam int SW = lzwd_pkg::STREAM_W;

	// fill count bounds
	localparam logic [NW-1:0] NF_MIN = NW'(lzwd_pkg::LIT_CODES);
	localparam logic [NW-1:0] NF_MAX = NW'(lzwd_pkg::DICT_ENTRIES);

	// sequencer and stream state
	lzwd_pkg::state_t  state_q, state_d;
	logic [1:0]        phase_q;
	logic [7:0]        held0_q, held1_q;
	lzwd_pkg::status_t err_q;
	lzwd_pkg::status_t pend_q;
	logic [NW-1:0]     nf_q;
	logic [CW-1:0]     prev_q;
	logic              havep_q;
	logic [SW-1:0]     code_q;
	logic              last_q;

	// per-code working registers
	logic [LW-1:0]     plen_q;
	logic [7:0]        pfirst_q;
	logic [LW-1:0]     walk_idx_q;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     total_q;
	logic [LW-1:0]     pos_q;
	logic [7:0]        extra_q;

	// output word register
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic              out_has_q;
	logic              out_last_q;
	lzwd_pkg::status_t out_status_q;

	// dictionary and stack ports
	logic [CW-1:0]     rd_addr;
	logic              dict_we;
	lzwd_pkg::entry_t  rd_ent;
	lzwd_pkg::entry_t  wr_ent;
	logic              stk_we;
	logic [LW-1:0]     stk_widx;
	logic [7:0]        stk_rdata;

	// decision terms, valid in the decide step
	logic              known;
	logic              room;
	logic              too_long;
	logic              start_on_code;
	logic              bad_first;
	logic              long_unknown;
	logic [LW-1:0]     plen_inc;

	// control outputs of the sequencer
	logic              accept;
	logic              out_free;
	logic              out_load;
	logic              emit_final;
	logic              finish;

	lzwd_dict u_dict (
		.clk     (clk),
		.rd_addr (rd_addr),
		.we      (dict_we),
		.wr_addr (nf_q[CW-1:0]),
		.wr_ent  (wr_ent),
		.rd_ent  (rd_ent)
	);

	lzwd_stack u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_widx[PW-1:0]),
		.wdata (rd_ent.suffix),
		.raddr (pos_q[PW-1:0]),
		.rdata (stk_rdata)
	);

	assign src.ready = (state_q == lzwd_pkg::S_IDLE);
	assign accept    = src.valid && src.ready;
	assign out_free  = !out_valid_q || dst.ready;

	assign known    = code_q < SW'(nf_q);
	assign room     = nf_q < NW'(lzwd_pkg::DICT_ENTRIES);
	assign plen_inc = plen_q + LW'(1);
	assign too_long = ({1'b0, plen_q} + (LW + 1)'(1)) > (LW + 1)'(lzwd_pkg::MAX_STRING);
	assign bad_first    = !havep_q && !known;
	assign long_unknown = havep_q && !known && too_long;
	// unknown code decodes as previous string plus its first byte
	assign start_on_code = known;
	assign emit_final    = (pos_q == total_q - LW'(1));
	assign stk_widx      = walk_idx_q - LW'(1);

	// new entry: known code takes its first byte, unknown one the previous first
	always_comb begin
		wr_ent.prefix = prev_q;
		wr_ent.suffix = known ? rd_ent.first : pfirst_q;
		wr_ent.first  = pfirst_q;
		wr_ent.len    = plen_inc;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lzwd_pkg::S_IDLE: begin
				if (accept && err_q == lzwd_pkg::ST_OK) begin
					if (phase_q == 2'd0) begin
						if (src.in_last) begin
							state_d = lzwd_pkg::S_STATUS;
						end
					end else begin
						state_d = lzwd_pkg::S_RDPREV;
					end
				end
			end
			lzwd_pkg::S_RDPREV: state_d = lzwd_pkg::S_RDCODE;
			lzwd_pkg::S_RDCODE: state_d = lzwd_pkg::S_DECIDE;
			lzwd_pkg::S_DECIDE: begin
				if (bad_first || long_unknown) begin
					state_d = lzwd_pkg::S_STATUS;
				end else if ((start_on_code ? rd_ent.len : plen_q) == LW'(1)) begin
					state_d = lzwd_pkg::S_WALK;
				end else begin
					state_d = lzwd_pkg::S_WALK;
				end
			end
			lzwd_pkg::S_WALK: begin
				if (walk_idx_q == LW'(1)) begin
					state_d = lzwd_pkg::S_EMIT_RD;
				end
			end
			lzwd_pkg::S_EMIT_RD: state_d = lzwd_pkg::S_EMIT_OUT;
			lzwd_pkg::S_EMIT_OUT: begin
				if (out_free) begin
					state_d = emit_final ? lzwd_pkg::S_IDLE : lzwd_pkg::S_EMIT_RD;
				end
			end
			lzwd_pkg::S_STATUS: begin
				if (out_free) begin
					state_d = lzwd_pkg::S_IDLE;
				end
			end
			default: state_d = lzwd_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		rd_addr  = prev_q;
		dict_we  = 1'b0;
		stk_we   = 1'b0;
		out_load = 1'b0;
		finish   = 1'b0;
		case (state_q)
			lzwd_pkg::S_RDPREV: rd_addr = prev_q;
			lzwd_pkg::S_RDCODE: rd_addr = code_q[CW-1:0];
			lzwd_pkg::S_DECIDE: begin
				rd_addr = start_on_code ? code_q[CW-1:0] : prev_q;
				dict_we = havep_q && room && !too_long;
			end
			lzwd_pkg::S_WALK: begin
				rd_addr = rd_ent.prefix;
				stk_we  = 1'b1;
			end
			lzwd_pkg::S_EMIT_OUT: begin
				out_load = out_free;
				finish   = out_free && emit_final;
			end
			lzwd_pkg::S_STATUS: begin
				out_load = out_free;
				finish   = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwd_pkg::S_IDLE;
			phase_q <= 2'd0;
			err_q   <= lzwd_pkg::ST_OK;
			pend_q  <= lzwd_pkg::ST_OK;
			nf_q    <= NW'(lzwd_pkg::LIT_CODES);
			havep_q <= 1'b0;
			prev_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// word intake
			if (accept) begin
				last_q <= src.in_last;
				pend_q <= lzwd_pkg::ST_OK;
				if (err_q != lzwd_pkg::ST_OK) begin
					// error latched: words dropped until the stream ends
					if (src.in_last) begin
						err_q   <= lzwd_pkg::ST_OK;
						nf_q    <= NW'(lzwd_pkg::LIT_CODES);
						havep_q <= 1'b0;
						phase_q <= 2'd0;
					end
				end else begin
					case (phase_q)
						2'd0: begin
							if (src.in_last) begin
								pend_q <= lzwd_pkg::ST_TRUNC;
							end else begin
								phase_q <= 2'd1;
							end
						end
						2'd1: begin
							if (!src.in_last) begin
								phase_q <= 2'd2;
							end
						end
						default: phase_q <= 2'd0;
					endcase
				end
			end
			// decide: dictionary update and previous code
			if (state_q == lzwd_pkg::S_DECIDE) begin
				if (bad_first) begin
					pend_q <= lzwd_pkg::ST_BAD_FIRST;
				end else if (!havep_q) begin
					prev_q  <= code_q[CW-1:0];
					havep_q <= 1'b1;
				end else if (known) begin
					if (room) begin
						if (too_long) begin
							pend_q <= lzwd_pkg::ST_TOO_LONG;
						end else begin
							nf_q <= nf_q + NW'(1);
						end
					end
					prev_q <= code_q[CW-1:0];
				end else if (too_long) begin
					pend_q <= lzwd_pkg::ST_TOO_LONG;
				end else if (room) begin
					prev_q <= nf_q[CW-1:0];
					nf_q   <= nf_q + NW'(1);
				end
			end
			// end of the word's work
			if (finish) begin
				if (last_q) begin
					err_q   <= lzwd_pkg::ST_OK;
					nf_q    <= NW'(lzwd_pkg::LIT_CODES);
					havep_q <= 1'b0;
					phase_q <= 2'd0;
				end else begin
					err_q <= pend_q;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				2'd0: held0_q <= src.in_byte;
				2'd1: begin
					held1_q <= src.in_byte;
					if (src.in_last) begin
						code_q <= {held0_q, src.in_byte};
					end else begin
						code_q <= {4'h0, held0_q, src.in_byte[7:4]};
					end
				end
				default: code_q <= {4'h0, held1_q[3:0], src.in_byte};
			endcase
		end
		if (state_q == lzwd_pkg::S_RDCODE) begin
			plen_q   <= rd_ent.len;
			pfirst_q <= rd_ent.first;
		end
		if (state_q == lzwd_pkg::S_DECIDE) begin
			pos_q <= '0;
			if (start_on_code) begin
				len_q      <= rd_ent.len;
				walk_idx_q <= rd_ent.len;
				total_q    <= rd_ent.len;
			end else begin
				len_q      <= plen_q;
				walk_idx_q <= plen_q;
				total_q    <= plen_inc;
				extra_q    <= pfirst_q;
			end
		end
		if (state_q == lzwd_pkg::S_WALK) begin
			walk_idx_q <= stk_widx;
		end
		if (state_q == lzwd_pkg::S_EMIT_OUT && out_free) begin
			pos_q <= pos_q + LW'(1);
		end
		if (out_load) begin
			if (state_q == lzwd_pkg::S_STATUS) begin
				out_data_q   <= 8'h00;
				out_has_q    <= 1'b0;
				out_last_q   <= 1'b1;
				out_status_q <= pend_q;
			end else begin
				out_data_q   <= (pos_q < len_q) ? stk_rdata : extra_q;
				out_has_q    <= 1'b1;
				out_last_q   <= emit_final;
				out_status_q <= emit_final ? pend_q : lzwd_pkg::ST_OK;
			end
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dst.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign dst.valid     = out_valid_q;
	assign dst.data_byte = out_data_q;
	assign dst.has_data  = out_has_q;
	assign dst.run_last  = out_last_q;
	assign dst.status    = out_status_q;

	// checks
	`LZWD_ASSERT_ALWAYS(a_nf_range, (nf_q >= NF_MIN) && (nf_q <= NF_MAX), "fill count out of range")
	`LZWD_ASSERT_IMPL(a_prev_known, havep_q && src.ready, NW'(prev_q) < nf_q, "previous code unknown")
	`LZWD_ASSERT_IMPL(a_walk_nonzero, state_q == lzwd_pkg::S_WALK, |walk_idx_q, "walk past start")
	`LZWD_ASSERT_IMPL(a_load_free, out_load, out_free, "output word overwritten")

endmodule

`default_nettype wire

FILE: tb/sv/tb_lzw_byte_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_lzw_byte_stream_decoder
// Self-checking bench for the 12-bit lzw byte stream decoder. Packed code
// streams go in as input words. A dictionary model, updated on each accepted
// word, works out the decoded words. Each output word is checked against the
// oldest expected word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lzw_byte_stream_decoder;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 400;

	typedef struct {
		logic [7:0] b;
		logic       last;
	} in_word_t;

	typedef struct {
		logic [7:0]        data;
		logic              has;
		logic              last;
		lzwd_pkg::status_t st;
	} out_word_t;

	logic clk;
	logic arst_n;

	lzwd_in_if  src ();
	lzwd_out_if dst ();

	lzw_byte_stream_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.dst    (dst)
	);

	// clock, period 2
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// dictionary model
	// ------------------------------------------------------------------
	logic [11:0]       dict_prefix [lzwd_pkg::DICT_ENTRIES];
	logic [7:0]        dict_suffix [lzwd_pkg::DICT_ENTRIES];
	logic [7:0]        dict_first  [lzwd_pkg::DICT_ENTRIES];
	logic [6:0]        dict_len    [lzwd_pkg::DICT_ENTRIES];
	logic [7:0]        walk_stack  [lzwd_pkg::MAX_STRING];
	int                free_code;
	int                prev_code;
	bit                have_prev;
	int                phase;
	logic [7:0]        held [2];
	lzwd_pkg::status_t err_state;

	out_word_t word_buf [$];   // decoded words for the word being modeled
	out_word_t decoded_q [$];  // decoded words still waiting at the output

	function automatic int clip_code(int c);
		return (c < lzwd_pkg::DICT_ENTRIES) ? c : 0;
	endfunction

	task automatic put_word(logic [7:0] d, logic h, lzwd_pkg::status_t s);
		out_word_t w;
		w.data = d;
		w.has  = h;
		w.last = 1'b0;
		w.st   = s;
		if (word_buf.size() < lzwd_pkg::MAX_STRING)
			word_buf.push_back(w);
	endtask

	task automatic restart_stream();
		free_code = lzwd_pkg::LIT_CODES;
		prev_code = 0;
		have_prev = 0;
		phase     = 0;
		err_state = lzwd_pkg::ST_OK;
	endtask

	// rebuild the string by walking the prefix chain backwards
	task automatic emit_string(int code);
		int c;
		int n;
		c = clip_code(code);
		n = int'(dict_len[c]);
		if (n > lzwd_pkg::MAX_STRING)
			n = lzwd_pkg::MAX_STRING;
		for (int i = n; i > 0; i--) begin
			walk_stack[i-1] = dict_suffix[c];
			c = clip_code(int'(dict_prefix[c]));
		end
		for (int i = 0; i < n; i++)
			put_word(walk_stack[i], 1'b1, lzwd_pkg::ST_OK);
	endtask

	task automatic add_entry(int prv, logic [7:0] extra);
		int p;
		p = clip_code(prv);
		if (free_code >= lzwd_pkg::DICT_ENTRIES)
			return;
		dict_prefix[free_code] = p[11:0];
		dict_suffix[free_code] = extra;
		dict_first[free_code]  = dict_first[p];
		dict_len[free_code]    = dict_len[p] + 7'd1;
		free_code++;
	endtask

	task automatic decode_code(int code, output lzwd_pkg::status_t s);
		int prv;
		int plen;
		int fresh;
		prv  = clip_code(prev_code);
		plen = int'(dict_len[prv]);
		s    = lzwd_pkg::ST_OK;
		if (!have_prev) begin
			if (code >= free_code) begin
				s = lzwd_pkg::ST_BAD_FIRST;
				return;
			end
			emit_string(code);
			prev_code = code;
			have_prev = 1;
		end else if (code < free_code) begin
			emit_string(code);
			if (free_code < lzwd_pkg::DICT_ENTRIES) begin
				if (plen + 1 > lzwd_pkg::MAX_STRING) begin
					s = lzwd_pkg::ST_TOO_LONG;
					return;
				end
				add_entry(prv, dict_first[code]);
			end
			prev_code = code;
		end else if (plen + 1 > lzwd_pkg::MAX_STRING) begin
			s = lzwd_pkg::ST_TOO_LONG;
		end else if (free_code < lzwd_pkg::DICT_ENTRIES) begin
			// unknown code: previous string plus its own first byte
			fresh = free_code;
			add_entry(prv, dict_first[prv]);
			emit_string(fresh);
			prev_code = fresh;
		end else begin
			// full dictionary: write it out, keep the previous code
			emit_string(prv);
			put_word(dict_first[prv], 1'b1, lzwd_pkg::ST_OK);
		end
	endtask

	task automatic flag_error(lzwd_pkg::status_t s);
		if (s == lzwd_pkg::ST_OK)
			return;
		err_state = s;
		if (word_buf.size() > 0)
			word_buf[word_buf.size()-1].st = s;
		else
			put_word(8'h00, 1'b0, s);
	endtask

	task automatic model_word(logic [7:0] b, logic last);
		int                code;
		lzwd_pkg::status_t s;
		word_buf.delete();
		if (err_state == lzwd_pkg::ST_OK) begin
			if (phase == 1) begin
				held[1] = b;
				if (last) begin
					code = int'({held[0], b});
				end else begin
					code = int'({held[0], b[7:4]});
					phase = 2;
				end
				decode_code(code, s);
				flag_error(s);
			end else if (phase == 2) begin
				code = int'({held[1][3:0], b});
				phase = 0;
				decode_code(code, s);
				flag_error(s);
			end else begin
				held[0] = b;
				if (last)
					flag_error(lzwd_pkg::ST_TRUNC);
				else
					phase = 1;
			end
		end
		if (last)
			restart_stream();
		if (word_buf.size() > 0)
			word_buf[word_buf.size()-1].last = 1'b1;
		foreach (word_buf[i])
			decoded_q.push_back(word_buf[i]);
	endtask

	initial begin
		for (int i = 0; i < lzwd_pkg::DICT_ENTRIES; i++) begin
			dict_prefix[i] = '0;
			dict_suffix[i] = (i < lzwd_pkg::LIT_CODES) ? i[7:0] : 8'h00;
			dict_first[i]  = (i < lzwd_pkg::LIT_CODES) ? i[7:0] : 8'h00;
			dict_len[i]    = (i < lzwd_pkg::LIT_CODES) ? 7'd1 : 7'd0;
		end
		held[0] = '0;
		held[1] = '0;
		restart_stream();
	end

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	in_word_t stim_q [$];
	int       total_words;
	int       sent_words;
	int       errors;
	bit       hold_req;
	bit       in_fire;
	int       quiet_cycles;

	task automatic push_word(logic [7:0] b, logic last);
		in_word_t w;
		w.b    = b;
		w.last = last;
		stim_q.push_back(w);
	endtask

	// codes go out in pairs, three words per pair; an optional 16-bit
	// code closes the stream, otherwise the final word carries last
	task automatic send_codes(int cq[$], bit tail_on, logic [15:0] tail);
		logic [11:0] c0;
		logic [11:0] c1;
		bit          fin;
		for (int i = 0; i + 1 < cq.size(); i += 2) begin
			c0  = cq[i][11:0];
			c1  = cq[i+1][11:0];
			fin = !tail_on && (i + 2 >= cq.size());
			push_word(c0[11:4], 1'b0);
			push_word({c0[3:0], c1[11:8]}, 1'b0);
			push_word(c1[7:0], fin);
		end
		if (tail_on) begin
			push_word(tail[15:8], 1'b0);
			push_word(tail[7:0], 1'b1);
		end
	endtask

	task automatic build_random_stream();
		int cq[$];
		int n;
		int nf;
		int r;
		n  = 2 * $urandom_range(1, 6);
		nf = lzwd_pkg::LIT_CODES;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (i == 0 || r < 55 || nf == lzwd_pkg::LIT_CODES)
				cq.push_back($urandom_range(0, 255));
			else if (r < 88)
				cq.push_back($urandom_range(lzwd_pkg::LIT_CODES, nf - 1));
			else if (r < 97)
				cq.push_back(nf);
			else
				cq.push_back($urandom_range(0, lzwd_pkg::DICT_ENTRIES - 1));
			if (i > 0)
				nf++;
		end
		if ($urandom_range(0, 1))
			send_codes(cq, 1, 16'($urandom_range(0, 65535)));
		else
			send_codes(cq, 0, 16'h0);
	endtask

	task automatic build_stimulus();
		int cq[$];
		int n;
		// literal extremes, then a known multi-byte code, 16-bit literal tail
		cq = {0, 255, 256, 255};
		send_codes(cq, 1, 16'h0041);
		// invalid first code; the words after it are ignored up to last
		cq = {300, 5};
		send_codes(cq, 0, 16'h0);
		push_word(8'hC3, 1'b0);
		push_word(8'h3C, 1'b1);
		// lone trailing word at stream start, before and after a two-code stream
		push_word(8'hAB, 1'b1);
		cq = {65, 66};
		send_codes(cq, 0, 16'h0);
		push_word(8'h5A, 1'b1);
		// unknown 16-bit closing code
		cq = {65, 66};
		send_codes(cq, 1, 16'hFFFF);
		// 16-bit code as the only code: invalid, then a literal
		push_word(8'h12, 1'b0);
		push_word(8'h34, 1'b1);
		push_word(8'h00, 1'b0);
		push_word(8'h41, 1'b1);
		// self-referencing codes grow one byte each until over-long
		cq = {97};
		for (int c = 256; c <= 320; c++)
			cq.push_back(c);
		send_codes(cq, 1, 16'h0061);

		n = 0;
		while (n < 180) begin
			if ($urandom_range(0, 99) < 15) begin
				// noise: random words, last on the final one
				repeat ($urandom_range(1, 8)) push_word(8'($urandom_range(0, 255)), 1'b0);
				push_word(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				build_random_stream();
			end
			n = stim_q.size();
		end
	endtask

	// ------------------------------------------------------------------
	// driver: sender idles 26%, then 78%, then never
	// ------------------------------------------------------------------
	function automatic int send_idle_pct();
		if (sent_words < total_words / 20)
			return 26;
		if (sent_words < total_words / 10)
			return 78;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (sent_words < total_words / 20)
			return 78;
		if (sent_words < total_words / 10)
			return 26;
		return 0;
	endfunction

	always @(negedge clk) begin
		if (arst_n && (!src.valid || in_fire)) begin
			if (stim_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
				src.valid   <= 1'b1;
				src.in_byte <= stim_q[0].b;
				src.in_last <= stim_q[0].last;
				stim_q.pop_front();
			end else begin
				src.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	int hold_left;
	bit hold_done;
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			dst.ready <= 1'b0;
		end else begin
			dst.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
		end
	end

	// ------------------------------------------------------------------
	// monitor, checker and watchdog
	// ------------------------------------------------------------------
	out_word_t want;
	always @(posedge clk) begin
		in_fire = 1'b0;
		if (arst_n) begin
			if (dst.valid && dst.ready) begin
				quiet_cycles = 0;
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected word data=%h has=%b last=%b status=%0d",
						$time, dst.data_byte, dst.has_data, dst.run_last, dst.status);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					if (dst.data_byte !== want.data || dst.has_data !== want.has ||
							dst.run_last !== want.last || dst.status !== want.st) begin
						$display("%0t: mismatch expected data=%h has=%b last=%b status=%0d",
							$time, want.data, want.has, want.last, want.st);
						$display("%0t:          actual   data=%h has=%b last=%b status=%0d",
							$time, dst.data_byte, dst.has_data, dst.run_last, dst.status);
						errors++;
					end
				end
			end
			if (src.valid && src.ready) begin
				quiet_cycles = 0;
				in_fire = 1'b1;
				model_word(src.in_byte, src.in_last);
				sent_words++;
				if (sent_words == 30)
					hold_req = 1;
			end
			quiet_cycles++;
			if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// run control
	// ------------------------------------------------------------------
	initial begin
		errors       = 0;
		sent_words   = 0;
		hold_req     = 0;
		hold_done    = 0;
		hold_left    = 0;
		in_fire      = 0;
		quiet_cycles = 0;
		arst_n       = 1'b0;
		src.valid    = 1'b0;
		src.in_byte  = 8'h00;
		src.in_last  = 1'b0;
		dst.ready    = 1'b0;
		build_stimulus();
		total_words = stim_q.size();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(sent_words == total_words && decoded_q.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && decoded_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
